[sv/brweg_pkg.sv]
// Package: constants, operation codes and register indexes for the bitstream reader.
`timescale 1ns / 1ps
package brweg_pkg;
  localparam int BufBytes    = 1024;
  localparam int AddrW       = $clog2(BufBytes);
  localparam int BitAddrW    = AddrW + 3;
  localparam int MaxFieldBits = 32;
  localparam int CntW        = $clog2(MaxFieldBits + 1);
  localparam int PosW        = 14;
  localparam int OffW        = 13;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_GET   = 3'd1,
    OP_PUT   = 3'd2,
    OP_SKIP  = 3'd3,
    OP_UEG   = 3'd4,
    OP_SEG   = 3'd5,
    OP_READ  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  localparam logic [1:0] CfgStartOffset = 2'd0;
  localparam logic [1:0] CfgTotalBits   = 2'd1;
endpackage

[sv/bitstream_reader_writer_exp_golomb.sv]
// Top level: byte buffer with bit-serial get/put/skip and Exp-Golomb decode.
`timescale 1ns / 1ps
// Bitstream reader/writer. A command is taken when start_i is high and busy_o and
// cfg_we_i are low; its result appears for one cycle with done_o and cannot be held
// off. All bit traffic goes through one byte RAM with a single registered read port,
// one bit per read-modify step: load, skip and idle commands finish straight from idle,
// read byte passes a memory read state, get reads the k available bits and shifts zeros
// in for the other n-k (n clamped count), put writes the k bits, Exp-Golomb scans the
// zero prefix, gets a z-bit suffix when z is not zero and maps the signed form last.
// No clearing pass: bytes must be loaded before they are read.
module bitstream_reader_writer_exp_golomb (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [13:0]              cfg_data_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               operation_i,
  input  logic [9:0]               byte_address_i,
  input  logic [7:0]               byte_value_i,
  input  logic [13:0]              bit_count_i,
  input  logic [31:0]              put_value_i,
  output logic                     done_o,
  output logic [31:0]              unsigned_value_o,
  output logic signed [31:0]       signed_value_o,
  output logic [13:0]              bit_position_o,
  output logic [13:0]              bits_remaining_o,
  output logic                     overflowed_o
);
  import brweg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MEM_RD, S_GET_RD, S_GET_BIT, S_PUT_RD, S_PUT_BIT,
    S_EG_RD, S_EG_BIT, S_EG_GS, S_EG_FIN, S_EG_SGN
  } state_e;

  state_e               state_q;
  logic [OffW-1:0]      offset_q;
  logic [PosW-1:0]      total_q, cur_q, z_q;
  logic [CntW-1:0]      n_q, k_q, i_q;
  logic [31:0]          v_q, sh_q, base_q, uval_q, sval_q;
  logic                 ovf_q, done_q, eg_q, sgn_q;

  logic [7:0]           mem [BufBytes];
  logic [7:0]           rdata_q;
  logic [AddrW-1:0]     raddr, waddr;
  logic [7:0]           wdata;
  logic                 we;

  logic [BitAddrW-1:0]  bit_addr;
  logic [2:0]           bsel;
  logic                 cur_bit;
  logic [7:0]           bmask;
  logic [PosW-1:0]      avail;
  logic [CntW-1:0]      n_in, n_eg, k_in, k_eg;

  // current bit address and bit picked from the byte read last cycle
  assign bit_addr = BitAddrW'(offset_q) + BitAddrW'(cur_q);
  assign bsel     = bit_addr[2:0];
  assign cur_bit  = rdata_q[3'd7 - bsel];
  assign bmask    = 8'h80 >> bsel;
  assign avail    = total_q - cur_q;

  // clamped counts for commands and for the Exp-Golomb suffix
  assign n_in = (bit_count_i > PosW'(MaxFieldBits)) ? CntW'(MaxFieldBits)
                                                      : CntW'(bit_count_i);
  assign n_eg = (z_q > PosW'(MaxFieldBits)) ? CntW'(MaxFieldBits) : CntW'(z_q);
  assign k_in = (PosW'(n_in) > avail) ? CntW'(avail) : n_in;
  assign k_eg = (PosW'(n_eg) > avail) ? CntW'(avail) : n_eg;

  // RAM port control
  always_comb begin
    raddr = bit_addr[BitAddrW-1:3];
    if (state_q == S_IDLE) raddr = AddrW'(byte_address_i);
    we    = 1'b0;
    waddr = bit_addr[BitAddrW-1:3];
    wdata = sh_q[31] ? (rdata_q | bmask) : (rdata_q & ~bmask);
    if (state_q == S_IDLE && start_i && !cfg_we_i && operation_i == OP_LOAD) begin
      we    = 1'b1;
      waddr = AddrW'(byte_address_i);
      wdata = byte_value_i;
    end else if (state_q == S_PUT_BIT) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      offset_q <= '0;
      total_q  <= '0;
      cur_q    <= '0;
      done_q   <= 1'b0;
      ovf_q    <= 1'b0;
      uval_q   <= '0;
      sval_q   <= '0;
      eg_q     <= 1'b0;
      sgn_q    <= 1'b0;
      z_q      <= '0;
      n_q      <= '0;
      k_q      <= '0;
      i_q      <= '0;
      v_q      <= '0;
      sh_q     <= '0;
      base_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_index_i == CfgStartOffset) begin
              offset_q <= cfg_data_i[OffW-1:0];
              cur_q    <= '0;
            end else if (cfg_index_i == CfgTotalBits) begin
              total_q <= cfg_data_i;
              cur_q   <= '0;
            end
          end else if (start_i) begin
            uval_q <= '0;
            sval_q <= '0;
            ovf_q  <= 1'b0;
            i_q    <= '0;
            v_q    <= '0;
            n_q    <= n_in;
            k_q    <= k_in;
            eg_q   <= 1'b0;
            sgn_q  <= (operation_i == OP_SEG);
            z_q    <= '0;
            base_q <= 32'h1;
            sh_q   <= put_value_i << (6'd32 - 6'(n_in));
            case (operation_i)
              OP_GET: begin
                if (n_in == '0) done_q <= 1'b1;
                else begin
                  ovf_q   <= (k_in < n_in);
                  state_q <= S_GET_RD;
                end
              end
              OP_PUT: begin
                if (n_in == '0) done_q <= 1'b1;
                else begin
                  ovf_q   <= (k_in < n_in);
                  state_q <= S_PUT_RD;
                end
              end
              OP_SKIP: begin
                done_q <= 1'b1;
                if (bit_count_i > avail) begin
                  cur_q <= total_q;
                  ovf_q <= 1'b1;
                end else begin
                  cur_q <= cur_q + bit_count_i;
                end
              end
              OP_UEG, OP_SEG: state_q <= S_EG_RD;
              OP_READ:        state_q <= S_MEM_RD;
              default:        done_q  <= 1'b1;
            endcase
          end
        end
        S_MEM_RD: begin
          uval_q  <= 32'(rdata_q);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        // suffix/field fetch, missing bits shift in as zero
        S_GET_RD: begin
          if (i_q == n_q) begin
            if (eg_q) state_q <= S_EG_FIN;
            else begin
              uval_q  <= v_q;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end else if (i_q >= k_q) begin
            v_q <= {v_q[30:0], 1'b0};
            i_q <= i_q + 1'b1;
          end else begin
            state_q <= S_GET_BIT;
          end
        end
        S_GET_BIT: begin
          v_q     <= {v_q[30:0], cur_bit};
          cur_q   <= cur_q + 1'b1;
          i_q     <= i_q + 1'b1;
          state_q <= S_GET_RD;
        end
        // read-modify-write of one bit per pass
        S_PUT_RD: begin
          if (i_q == k_q) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_PUT_BIT;
          end
        end
        S_PUT_BIT: begin
          sh_q    <= {sh_q[30:0], 1'b0};
          cur_q   <= cur_q + 1'b1;
          i_q     <= i_q + 1'b1;
          state_q <= S_PUT_RD;
        end
        // leading zero scan
        S_EG_RD: begin
          if (cur_q < total_q) state_q <= S_EG_BIT;
          else begin
            ovf_q   <= 1'b1;
            state_q <= S_EG_GS;
          end
        end
        S_EG_BIT: begin
          cur_q <= cur_q + 1'b1;
          if (cur_bit) state_q <= S_EG_GS;
          else if (cur_q + 1'b1 >= total_q) begin
            ovf_q   <= 1'b1;
            state_q <= S_EG_GS;
          end else begin
            z_q     <= z_q + 1'b1;
            base_q  <= {base_q[30:0], 1'b0};
            state_q <= S_EG_RD;
          end
        end
        S_EG_GS: begin
          n_q  <= n_eg;
          k_q  <= k_eg;
          i_q  <= '0;
          v_q  <= '0;
          eg_q <= 1'b1;
          if (k_eg < n_eg) ovf_q <= 1'b1;
          state_q <= (n_eg == '0) ? S_EG_FIN : S_GET_RD;
        end
        S_EG_FIN: begin
          uval_q <= base_q + v_q - 32'h1;
          if (sgn_q) state_q <= S_EG_SGN;
          else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_EG_SGN: begin
          // even codes map to minus half, odd ones to half rounded up
          sval_q  <= uval_q[0] ? ({1'b0, uval_q[31:1]} + 32'h1)
                               : (32'h0 - {1'b0, uval_q[31:1]});
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign unsigned_value_o = uval_q;
  assign signed_value_o   = $signed(sval_q);
  assign bit_position_o   = cur_q;
  assign bits_remaining_o = avail;
  assign overflowed_o     = ovf_q;
endmodule

[sim/brweg_scoreboard.sv]
// Checker for the bitstream reader: predicts every result and compares it.
`timescale 1ns / 1ps
module brweg_scoreboard
  import brweg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [13:0]        cfg_data_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         operation_i,
  input  logic [9:0]         byte_address_i,
  input  logic [7:0]         byte_value_i,
  input  logic [13:0]        bit_count_i,
  input  logic [31:0]        put_value_i,
  input  logic               done_i,
  input  logic [31:0]        unsigned_value_i,
  input  logic [31:0]        signed_value_i,
  input  logic [13:0]        bit_position_i,
  input  logic [13:0]        bits_remaining_i,
  input  logic               overflowed_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        results_o
);

  typedef struct packed {
    logic [31:0] uval;
    logic [31:0] sval;
    logic [13:0] pos;
    logic [13:0] remain;
    logic        ovf;
  } bs_result_t;

  // Shadow copy of the block's state
  logic [7:0]  shadow_mem [BufBytes];
  int unsigned cur_bit;
  int unsigned bit_offset;
  int unsigned stream_bits;
  bs_result_t  expected_q[$];

  function automatic int unsigned stream_addr(int unsigned i);
    return (bit_offset + cur_bit + i) % (BufBytes * 8);
  endfunction

  function automatic logic stream_bit(int unsigned i);
    int unsigned a;
    a = stream_addr(i);
    return shadow_mem[a >> 3][7 - (a & 7)];
  endfunction

  // Get up to 32 bits MSB first, zero fill past the end
  function automatic logic [31:0] fetch_field(int unsigned count, inout logic ovf);
    int unsigned n, k, avail;
    logic [63:0] v;
    n = (count > MaxFieldBits) ? MaxFieldBits : count;
    avail = stream_bits - cur_bit;
    v = '0;
    if (n == 0) return '0;
    k = (n > avail) ? avail : n;
    if (k < n) ovf = 1'b1;
    for (int unsigned i = 0; i < k; i++) v = (v << 1) | stream_bit(i);
    cur_bit += k;
    v = v << (n - k);
    return v[31:0];
  endfunction

  function automatic bs_result_t predict_command(op_e op, logic [9:0] addr, logic [7:0] bval,
                                                 logic [13:0] cnt, logic [31:0] pv);
    bs_result_t r;
    int unsigned n, k, avail, zeros, a;
    logic [31:0] base, code;
    logic found;
    logic ovf;
    r = '0;
    ovf = 1'b0;
    case (op)
      OP_LOAD: shadow_mem[addr] = bval;
      OP_GET:  r.uval = fetch_field(cnt, ovf);
      OP_PUT: begin
        n = (cnt > MaxFieldBits) ? MaxFieldBits : cnt;
        avail = stream_bits - cur_bit;
        if (n != 0) begin
          k = (n > avail) ? avail : n;
          if (k < n) ovf = 1'b1;
          for (int unsigned i = 0; i < k; i++) begin
            a = stream_addr(i);
            shadow_mem[a >> 3][7 - (a & 7)] = pv[n - 1 - i];
          end
          cur_bit += k;
        end
      end
      OP_SKIP: begin
        if (cnt > stream_bits - cur_bit) begin
          cur_bit = stream_bits;
          ovf = 1'b1;
        end else begin
          cur_bit += cnt;
        end
      end
      OP_UEG, OP_SEG: begin
        zeros = 0;
        base = 32'd1;
        found = 1'b0;
        // leading zero scan; a trailing zero at the end of the stream is not counted
        while (cur_bit < stream_bits) begin
          logic b;
          b = stream_bit(0);
          cur_bit++;
          if (b) begin
            found = 1'b1;
            break;
          end
          if (cur_bit >= stream_bits) break;
          zeros++;
          base = base << 1;
        end
        if (!found) ovf = 1'b1;
        code = base - 32'd1 + fetch_field(zeros, ovf);
        r.uval = code;
        if (op == OP_SEG) r.sval = code[0] ? (code >> 1) + 32'd1 : 32'd0 - (code >> 1);
      end
      OP_READ: r.uval = {24'd0, shadow_mem[addr]};
      default: ;
    endcase
    r.ovf = ovf;
    r.pos = cur_bit[13:0];
    r.remain = 14'(stream_bits - cur_bit);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    fail_count_o++;
  endtask

  // Watch both channels; the older transaction is checked before the new one is queued
  always @(posedge clk_i or negedge rst_ni) begin
    bs_result_t want;
    if (!rst_ni) begin
      cur_bit      = 0;
      bit_offset   = 0;
      stream_bits  = 0;
      fail_count_o = 0;
      results_o    = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (done_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", unsigned_value_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (unsigned_value_i !== want.uval)
            report_mismatch("unsigned_value", unsigned_value_i, want.uval);
          if (signed_value_i !== want.sval)
            report_mismatch("signed_value", signed_value_i, want.sval);
          if (bit_position_i !== want.pos)
            report_mismatch("bit_position", 32'(bit_position_i), 32'(want.pos));
          if (bits_remaining_i !== want.remain)
            report_mismatch("bits_remaining", 32'(bits_remaining_i), 32'(want.remain));
          if (overflowed_i !== want.ovf)
            report_mismatch("overflowed", 32'(overflowed_i), 32'(want.ovf));
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_command(op_e'(operation_i), byte_address_i,
                                             byte_value_i, bit_count_i, put_value_i));
      if (cfg_we_i) begin
        if (cfg_index_i == CfgStartOffset) begin
          bit_offset = cfg_data_i[12:0];
          cur_bit = 0;
        end else if (cfg_index_i == CfgTotalBits) begin
          stream_bits = cfg_data_i;
          cur_bit = 0;
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[sim/bitstream_reader_writer_exp_golomb_tb.sv]
// Testbench top: clock, reset, command stimulus and verdict for the bitstream reader.
`timescale 1ns / 1ps
module bitstream_reader_writer_exp_golomb_tb;
  import brweg_pkg::*;

  localparam int unsigned StallLimit = 100000;
  localparam int unsigned RandomItems = 700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CfgStartOffset;
  logic [13:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic [2:0]  operation_i = OP_LOAD;
  logic [9:0]  byte_address_i = '0;
  logic [7:0]  byte_value_i = '0;
  logic [13:0] bit_count_i = '0;
  logic [31:0] put_value_i = '0;
  logic        busy_o, done_o, overflowed_o;
  logic [31:0] unsigned_value_o;
  logic signed [31:0] signed_value_o;
  logic [13:0] bit_position_o, bits_remaining_o;
  int unsigned fail_count, pending, results;
  int unsigned sent_count = 0;
  int unsigned idle_pct = 20;
  int unsigned stall_cycles = 0;

  bitstream_reader_writer_exp_golomb DUT (.*);

  brweg_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .start_i, .busy_i(busy_o),
    .operation_i, .byte_address_i, .byte_value_i, .bit_count_i, .put_value_i,
    .done_i(done_o), .unsigned_value_i(unsigned_value_o), .signed_value_i(signed_value_o),
    .bit_position_i(bit_position_o), .bits_remaining_i(bits_remaining_o),
    .overflowed_i(overflowed_o), .fail_count_o(fail_count), .pending_o(pending),
    .results_o(results)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("Watchdog expired after %0d quiet cycles", stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One command transaction, then maybe a random gap
  task automatic issue(op_e op, logic [9:0] addr, logic [7:0] bval, logic [13:0] cnt,
                       logic [31:0] pv);
    operation_i    <= op;
    byte_address_i <= addr;
    byte_value_i   <= bval;
    bit_count_i    <= cnt;
    put_value_i    <= pv;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sent_count++;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Drain, then set both registers (position returns to zero)
  task automatic configure(int unsigned offs, int unsigned total);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgStartOffset;
    cfg_data_i  <= 14'(offs);
    @(posedge clk_i);
    cfg_index_i <= CfgTotalBits;
    cfg_data_i  <= 14'(total);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic put_exp_golomb();
    int unsigned z, len;
    logic [31:0] code;
    z = $urandom_range(0, 15);
    len = 2 * z + 1;
    code = (32'd1 << z) | ($urandom & ((32'd1 << z) - 1));
    issue(OP_PUT, 10'($urandom), 8'($urandom), 14'(len), ($urandom << len) | code);
  endtask

  initial begin
    int unsigned rnd_done, offs, total, n, pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole buffer so that no read ever hits an unloaded byte
    for (int i = 0; i < BufBytes; i++)
      issue(OP_LOAD, 10'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), '0, '0);

    // Directed: zero counts, full words, wrap at the end of the buffer, overruns
    configure(8191, 8192);
    issue(OP_READ, 10'h3FF, '0, '0, '0);
    issue(OP_GET, '0, '0, 14'd0, '0);
    issue(OP_PUT, '0, '0, 14'd0, 32'hFFFF_FFFF);
    issue(OP_PUT, '0, '0, 14'd8192, 32'hFFFF_FFFF);
    issue(OP_PUT, '0, '0, 14'd32, 32'h0000_0000);
    issue(OP_PUT, '0, '0, 14'd1, 32'h0000_0001);
    issue(OP_PUT, '0, '0, 14'd32, 32'h0000_0000);
    issue(OP_PUT, '0, '0, 14'd32, 32'h0000_0000);
    issue(OP_PUT, '0, '0, 14'd9, 32'h0000_0100);
    configure(8191, 8192);
    issue(OP_GET, '0, '0, 14'd33, '0);
    issue(OP_SEG, '0, '0, '0, '0);        // 32 zeros: code wraps to all ones
    issue(OP_UEG, '0, '0, '0, '0);        // prefix longer than a word
    issue(OP_SKIP, '0, '0, 14'd8192, '0);
    issue(OP_GET, '0, '0, 14'd5, '0);
    issue(OP_UEG, '0, '0, '0, '0);
    configure(0, 0);
    issue(OP_GET, '0, '0, 14'd1, '0);
    issue(OP_SEG, '0, '0, '0, '0);
    issue(OP_SKIP, '0, '0, 14'd0, '0);
    configure(4000, 3);
    issue(OP_PUT, '0, '0, 14'd3, 32'd0);
    configure(4000, 3);
    issue(OP_UEG, '0, '0, '0, '0);        // stream ends inside the zero run
    issue(OP_LOAD, 10'h3FF, 8'hFF, '0, '0);

    // Random: write codes into a window, rewind, read them back with noise mixed in
    rnd_done = 0;
    while (rnd_done < RandomItems) begin
      idle_pct = (rnd_done < RandomItems / 3) ? 20 : (rnd_done < 2 * RandomItems / 3) ? 66 : 0;
      case ($urandom_range(5))
        0: begin offs = 0; total = 8192; end
        1: begin offs = 8191; total = $urandom_range(1, 8192); end
        2: begin offs = $urandom_range(8191); total = $urandom_range(0, 40); end
        default: begin offs = $urandom_range(8191); total = $urandom_range(8192); end
      endcase
      n = $urandom_range(8, 30);
      configure(offs, total);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(4) != 0) put_exp_golomb();
        else issue(OP_PUT, 10'($urandom), 8'($urandom), 14'($urandom_range(0, 40)),
                   $urandom);
      end
      configure(offs, total);
      for (int unsigned i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        if (pick < 40)      issue(OP_UEG, 10'($urandom), 8'($urandom), 14'($urandom),
                                  $urandom);
        else if (pick < 70) issue(OP_SEG, 10'($urandom), 8'($urandom), 14'($urandom),
                                  $urandom);
        else if (pick < 80) issue(OP_GET, 10'($urandom), 8'($urandom),
                                  14'($urandom_range(0, 40)), $urandom);
        else if (pick < 85) issue(OP_SKIP, 10'($urandom), 8'($urandom),
                                  14'(($urandom_range(3) == 0) ? $urandom_range(8192)
                                                              : $urandom_range(0, 20)),
                                  $urandom);
        else if (pick < 90) issue(OP_PUT, 10'($urandom), 8'($urandom),
                                  14'($urandom_range(0, 40)), $urandom);
        else if (pick < 95) issue(OP_LOAD, 10'($urandom), 8'($urandom), 14'($urandom),
                                  $urandom);
        else                issue(OP_READ, 10'($urandom), 8'($urandom), 14'($urandom),
                                  $urandom);
      end
      rnd_done += 2 * n;
    end

    // Drain and give the verdict
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d command transactions and %0d results over many window settings,",
             sent_count, results);
    $display("including buffer wrap, overruns and Exp-Golomb codes up to and past a word.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/brweg_pkg.sv
sv/bitstream_reader_writer_exp_golomb.sv
sim/brweg_scoreboard.sv
sim/bitstream_reader_writer_exp_golomb_tb.sv
